@@ design/real_to_complex_downconverter_core_macros.svh @@
// ----------------------------------------------------------------------------
// Downconverter assertion macros
// Shared concurrent assertion forms, clocked on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef REAL_TO_COMPLEX_DOWNCONVERTER_CORE_MACROS_SVH
`define REAL_TO_COMPLEX_DOWNCONVERTER_CORE_MACROS_SVH

// Same-cycle implication.
`define RTCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RTCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/rtcd_pkg.sv @@
// ----------------------------------------------------------------------------
// Downconverter package
// Widths, register and mode codes, and the quarter-wave cos/sin tables.
// ----------------------------------------------------------------------------
package rtcd_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int PHASE_BITS     = 32;
  localparam int TBL_ADDR_BITS  = 10;
  localparam int QTR_BITS       = TBL_ADDR_BITS - 2;
  localparam int QTR_SIZE       = 1 << QTR_BITS;

  localparam int STEP_W         = 32;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_INDEX_W    = 2;
  localparam int MODE_W         = 2;

  localparam int COEF_FRAC      = 15;
  localparam int COEF_W         = COEF_FRAC + 2;
  localparam int PROD_W         = SAMPLE_BITS + COEF_W;
  localparam int MIX_W          = SAMPLE_BITS + 1;
  localparam int SUM_W          = MIX_W + 1;
  localparam int OUT_W          = 18;

  localparam logic signed [COEF_W-1:0] COEF_ONE   = COEF_W'(1 << COEF_FRAC);
  localparam logic signed [COEF_W-1:0] COEF_ZERO  = '0;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (COEF_FRAC - 1));

  // Mix modes
  localparam logic [MODE_W-1:0] MODE_PASS = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NCO  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QTR  = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MIX_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DECIMATE   = 2'd2;

  // Quarter-wave table: unsigned Q0.15 magnitudes capped at 32767
  typedef logic [QTR_SIZE-1:0][COEF_FRAC-1:0] qtab_t;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Taylor series of cos and sin in Q2.30 over the first quadrant.
  function automatic qtab_t build_qtab(input logic want_sin);
    qtab_t       tab;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] cp;
    logic [63:0] cn;
    logic [63:0] sp;
    logic [63:0] sn;
    logic [63:0] v;
    logic [63:0] rnd;
    tab = '0;
    for (int r = 0; r < QTR_SIZE; r++) begin
      x    = (PI_HALF_Q30 * 64'(r)) >> QTR_BITS;
      term = Q30_ONE;
      cp   = '0;
      cn   = '0;
      sp   = '0;
      sn   = '0;
      for (int n = 0; n < 18; n++) begin
        if (n > 0) begin
          term = ((term * x) >> 30) / 64'(n);
        end
        case (n % 4)
          0:       cp = cp + term;
          1:       sp = sp + term;
          2:       cn = cn + term;
          default: sn = sn + term;
        endcase
      end
      if (want_sin) begin
        v = (sp > sn) ? sp - sn : 64'd0;
      end else begin
        v = (cp > cn) ? cp - cn : 64'd0;
      end
      rnd = (v + (64'd1 << 14)) >> 15;
      tab[r] = (rnd > 64'd32767) ? {COEF_FRAC{1'b1}} : rnd[COEF_FRAC-1:0];
    end
    return tab;
  endfunction

  localparam qtab_t COS_QTAB = build_qtab(1'b0);
  localparam qtab_t SIN_QTAB = build_qtab(1'b1);

endpackage

@@ design/real_to_complex_downconverter_core.sv @@
// ----------------------------------------------------------------------------
// Real-to-complex downconverter core: pass, NCO or quarter-rate mix, decimate-by-two.
// Path: input transfer into the input stage register, then into the result register.
// Throughput: one sample per cycle while the result side does not stall; half rate out
// when decimating. Synchronous active-low reset clears modes, phase, pair and valid state.
// ----------------------------------------------------------------------------
module real_to_complex_downconverter_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input sample channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rtcd_pkg::SAMPLE_BITS-1:0] in_sample,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [rtcd_pkg::OUT_W-1:0]     out_i_out,
  output logic signed [rtcd_pkg::OUT_W-1:0]     out_q_out,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rtcd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rtcd_pkg::CFG_DATA_W-1:0]       cfg_data
);

`include "real_to_complex_downconverter_core_macros.svh"

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; the port is meant to be
  // driven only while the datapath is drained.
  // --------------------------------------------------------------------------
  logic [rtcd_pkg::MODE_W-1:0] mix_mode_r;
  logic [rtcd_pkg::STEP_W-1:0] phase_step_r;
  logic                        decimate_two_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_mode_r     <= rtcd_pkg::MODE_PASS;
      phase_step_r   <= '0;
      decimate_two_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtcd_pkg::REG_MIX_MODE:   mix_mode_r     <= cfg_data[rtcd_pkg::MODE_W-1:0];
        rtcd_pkg::REG_PHASE_STEP: phase_step_r   <= cfg_data[rtcd_pkg::STEP_W-1:0];
        rtcd_pkg::REG_DECIMATE:   decimate_two_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. The result register moves when it is empty or its transfer
  // completes; the input stage moves into it on the same edge, so a new sample
  // is taken every cycle unless the result side holds.
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic s1_move;
  logic in_accept;

  assign out_adv   = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && out_adv;
  assign in_stall  = s1_valid_r && !out_adv;
  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Phase state and mixing coefficient. Every mode is folded into a pair of
  // Q1.15 multipliers: pass uses (1, 0), quarter rate steps through
  // (1, 0), (0, -1), (-1, 0), (0, 1), and NCO reads the quarter-wave table at
  // the top accumulator bits and mirrors it by quadrant. Multiplying by exactly
  // one and rounding returns the sample unchanged, so one datapath serves all.
  // --------------------------------------------------------------------------
  logic [rtcd_pkg::PHASE_BITS-1:0]    phase_accum_r;
  logic [1:0]                         quarter_r;
  logic [rtcd_pkg::TBL_ADDR_BITS-1:0] tbl_addr;
  logic [1:0]                         tbl_quad;
  logic [rtcd_pkg::QTR_BITS-1:0]      tbl_row;
  logic signed [rtcd_pkg::COEF_W-1:0] c0;
  logic signed [rtcd_pkg::COEF_W-1:0] s0;
  logic signed [rtcd_pkg::COEF_W-1:0] coef_cos_nxt;
  logic signed [rtcd_pkg::COEF_W-1:0] coef_sin_nxt;
  logic                               nco_step;

  assign tbl_addr = phase_accum_r[rtcd_pkg::PHASE_BITS-1 -: rtcd_pkg::TBL_ADDR_BITS];
  assign tbl_quad = tbl_addr[rtcd_pkg::TBL_ADDR_BITS-1 -: 2];
  assign tbl_row  = tbl_addr[rtcd_pkg::QTR_BITS-1:0];
  assign c0       = $signed({2'b00, rtcd_pkg::COS_QTAB[tbl_row]});
  assign s0       = $signed({2'b00, rtcd_pkg::SIN_QTAB[tbl_row]});
  assign nco_step = in_accept && (mix_mode_r == rtcd_pkg::MODE_NCO);

  always_comb begin
    coef_cos_nxt = rtcd_pkg::COEF_ONE;
    coef_sin_nxt = rtcd_pkg::COEF_ZERO;
    case (mix_mode_r)
      rtcd_pkg::MODE_NCO: begin
        case (tbl_quad)
          2'd0: begin
            coef_cos_nxt = c0;
            coef_sin_nxt = s0;
          end
          2'd1: begin
            coef_cos_nxt = -s0;
            coef_sin_nxt = c0;
          end
          2'd2: begin
            coef_cos_nxt = -c0;
            coef_sin_nxt = -s0;
          end
          default: begin
            coef_cos_nxt = s0;
            coef_sin_nxt = -c0;
          end
        endcase
      end
      rtcd_pkg::MODE_QTR: begin
        case (quarter_r)
          2'd0: begin
            coef_cos_nxt = rtcd_pkg::COEF_ONE;
            coef_sin_nxt = rtcd_pkg::COEF_ZERO;
          end
          2'd1: begin
            coef_cos_nxt = rtcd_pkg::COEF_ZERO;
            coef_sin_nxt = -rtcd_pkg::COEF_ONE;
          end
          2'd2: begin
            coef_cos_nxt = -rtcd_pkg::COEF_ONE;
            coef_sin_nxt = rtcd_pkg::COEF_ZERO;
          end
          default: begin
            coef_cos_nxt = rtcd_pkg::COEF_ZERO;
            coef_sin_nxt = rtcd_pkg::COEF_ONE;
          end
        endcase
      end
      default: begin
        // pass-through, and the unused mode code behaves the same
        coef_cos_nxt = rtcd_pkg::COEF_ONE;
        coef_sin_nxt = rtcd_pkg::COEF_ZERO;
      end
    endcase
  end

  // Advance the phase only on a transfer in the matching mode, after use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_accum_r <= '0;
      quarter_r     <= '0;
    end else if (in_accept) begin
      if (mix_mode_r == rtcd_pkg::MODE_NCO) begin
        phase_accum_r <= phase_accum_r + rtcd_pkg::PHASE_BITS'(phase_step_r);
      end
      if (mix_mode_r == rtcd_pkg::MODE_QTR) begin
        quarter_r <= quarter_r + 2'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: sample and its coefficient pair.
  // --------------------------------------------------------------------------
  logic signed [rtcd_pkg::SAMPLE_BITS-1:0] s1_sample_r;
  logic signed [rtcd_pkg::COEF_W-1:0]      s1_cos_r;
  logic signed [rtcd_pkg::COEF_W-1:0]      s1_sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r <= in_sample;
      s1_cos_r    <= coef_cos_nxt;
      s1_sin_r    <= coef_sin_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result stage: multiply, round half up (arithmetic shift floors), then
  // either emit or pair up with the held first half.
  // --------------------------------------------------------------------------
  logic signed [rtcd_pkg::PROD_W-1:0] prod_i;
  logic signed [rtcd_pkg::PROD_W-1:0] prod_q;
  logic signed [rtcd_pkg::PROD_W-1:0] shift_i;
  logic signed [rtcd_pkg::PROD_W-1:0] shift_q;
  logic signed [rtcd_pkg::MIX_W-1:0]  mix_i;
  logic signed [rtcd_pkg::MIX_W-1:0]  mix_q;
  logic signed [rtcd_pkg::SUM_W-1:0]  sum_i;
  logic signed [rtcd_pkg::SUM_W-1:0]  sum_q;
  logic signed [rtcd_pkg::MIX_W-1:0]  held_i_r;
  logic signed [rtcd_pkg::MIX_W-1:0]  held_q_r;
  logic                               pair_pending_r;
  logic                               emit;
  logic                               first_half;
  logic signed [rtcd_pkg::OUT_W-1:0]  res_i_nxt;
  logic signed [rtcd_pkg::OUT_W-1:0]  res_q_nxt;
  logic signed [rtcd_pkg::OUT_W-1:0]  out_i_r;
  logic signed [rtcd_pkg::OUT_W-1:0]  out_q_r;

  assign prod_i  = rtcd_pkg::PROD_W'(s1_sample_r) * rtcd_pkg::PROD_W'(s1_cos_r);
  assign prod_q  = rtcd_pkg::PROD_W'(s1_sample_r) * rtcd_pkg::PROD_W'(s1_sin_r);
  assign shift_i = (prod_i + rtcd_pkg::ROUND_HALF) >>> rtcd_pkg::COEF_FRAC;
  assign shift_q = (prod_q + rtcd_pkg::ROUND_HALF) >>> rtcd_pkg::COEF_FRAC;
  assign mix_i   = shift_i[rtcd_pkg::MIX_W-1:0];
  assign mix_q   = shift_q[rtcd_pkg::MIX_W-1:0];
  assign sum_i   = rtcd_pkg::SUM_W'(mix_i) + rtcd_pkg::SUM_W'(held_i_r);
  assign sum_q   = rtcd_pkg::SUM_W'(mix_q) + rtcd_pkg::SUM_W'(held_q_r);

  // Without decimation every sample emits; with it only the second of a pair.
  assign emit       = !decimate_two_r || pair_pending_r;
  assign first_half = s1_move && decimate_two_r && !pair_pending_r;

  always_comb begin
    if (decimate_two_r) begin
      res_i_nxt = rtcd_pkg::OUT_W'(sum_i);
      res_q_nxt = rtcd_pkg::OUT_W'(sum_q);
    end else begin
      res_i_nxt = rtcd_pkg::OUT_W'(mix_i);
      res_q_nxt = rtcd_pkg::OUT_W'(mix_q);
    end
  end

  // Pair state: hold the first half, drop it when decimation is off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_pending_r <= 1'b0;
    end else if (s1_move) begin
      pair_pending_r <= decimate_two_r && !pair_pending_r;
    end
  end

  always_ff @(posedge clk) begin
    if (first_half) begin
      held_i_r <= mix_i;
      held_q_r <= mix_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && emit) begin
      out_i_r <= res_i_nxt;
      out_q_r <= res_q_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_i_out = out_i_r;
  assign out_q_out = out_q_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `RTCD_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid_r, "input stalled with empty stage")
  `RTCD_ASSERT_NEXT(a_first_half_silent, first_half, !out_valid_r, "first half emitted")
  `RTCD_ASSERT_NEXT(a_no_pair_when_off, s1_move && !decimate_two_r, !pair_pending_r, "pair kept")
  `RTCD_ASSERT_NEXT(a_phase_holds, !nco_step, $stable(phase_accum_r), "phase moved off NCO")

endmodule

@@ tb/real_to_complex_downconverter_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Downconverter core testbench
// Streams real samples through pass, NCO, quarter-rate and spare mix modes,
// with and without pair decimation. A predictor run on each input transfer keeps its own
// phase, quarter and half-pair state and queues the expected I/Q results.
// A monitor compares each result transfer with the oldest expectation.
// ----------------------------------------------------------------------------
module real_to_complex_downconverter_core_test;
  import rtcd_pkg::*;

  // Mode value with no mixing of its own; it must behave like pass-through.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int WAVE_SIZE = 1 << TBL_ADDR_BITS;
  localparam int LONG_HOLD = 120;

  typedef struct packed {
    logic signed [OUT_W-1:0] i_val;
    logic signed [OUT_W-1:0] q_val;
  } iq_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [OUT_W-1:0]       out_i_out;
  logic signed [OUT_W-1:0]       out_q_out;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_INDEX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]         cfg_data = '0;

  real_to_complex_downconverter_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_i_out (out_i_out),
    .out_q_out (out_q_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Full-wave phasor tables, Q1.15
  int cos_wave [WAVE_SIZE];
  int sin_wave [WAVE_SIZE];

  // Predictor copy of the configuration and mixer state
  logic [MODE_W-1:0] cur_mode = MODE_PASS;
  logic [STEP_W-1:0] cur_step = '0;
  logic              cur_decim = 1'b0;
  logic [PHASE_BITS-1:0] phase_acc = '0;
  logic [1:0]        quarter_pos = '0;
  logic              half_held = 1'b0;
  longint            held_i = 0;
  longint            held_q = 0;

  logic signed [SAMPLE_BITS-1:0] pending_samples [$];
  iq_t expected_iq [$];

  // Handshake bookkeeping
  bit offer_open = 1'b0;
  int send_wait = 0;
  int send_gap_max = 0;
  int recv_wait = 0;
  int recv_gap_max = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int long_holds = 0;

  int samples_sent = 0;
  int results_seen = 0;
  int error_count = 0;
  iq_t want;

  // Taylor series over one quadrant in Q2.30, rounded and capped to Q1.15.
  function automatic void taylor_quadrant(input longint unsigned ang,
                                          output int c, output int s);
    longint unsigned term, c_pos, c_neg, s_pos, s_neg, diff, r;
    term  = 64'd1 << 30;
    c_pos = 0;
    c_neg = 0;
    s_pos = 0;
    s_neg = 0;
    for (int n = 0; n < 18; n++) begin
      if (n > 0) begin
        term = ((term * ang) >> 30) / longint'(n);
      end
      case (n % 4)
        0:       c_pos += term;
        1:       s_pos += term;
        2:       c_neg += term;
        default: s_neg += term;
      endcase
    end
    diff = (c_pos > c_neg) ? c_pos - c_neg : 0;
    r = (diff + (64'd1 << 14)) >> 15;
    c = (r > 32767) ? 32767 : int'(r);
    diff = (s_pos > s_neg) ? s_pos - s_neg : 0;
    r = (diff + (64'd1 << 14)) >> 15;
    s = (r > 32767) ? 32767 : int'(r);
  endfunction

  // Mirror the first quadrant into all four.
  function automatic void build_wave_tables();
    int c0, s0, r, quad;
    longint unsigned ang;
    for (int k = 0; k < WAVE_SIZE; k++) begin
      r    = k % QTR_SIZE;
      quad = k / QTR_SIZE;
      ang  = (64'd1686629713 * longint'(r)) >> QTR_BITS;
      taylor_quadrant(ang, c0, s0);
      case (quad)
        0:       begin cos_wave[k] = c0;  sin_wave[k] = s0;  end
        1:       begin cos_wave[k] = -s0; sin_wave[k] = c0;  end
        2:       begin cos_wave[k] = -c0; sin_wave[k] = -s0; end
        default: begin cos_wave[k] = s0;  sin_wave[k] = -c0; end
      endcase
    end
  endfunction

  // Mix one accepted sample and queue the result it causes, if any.
  function automatic void downconvert_sample(input logic signed [SAMPLE_BITS-1:0] smp);
    longint s, ri, rq;
    int addr;
    s = longint'(smp);
    if (cur_mode == MODE_NCO) begin
      addr = int'(phase_acc[PHASE_BITS-1 -: TBL_ADDR_BITS]);
      // Round to nearest, ties toward plus infinity.
      ri = (s * longint'(cos_wave[addr]) + 16384) >>> 15;
      rq = (s * longint'(sin_wave[addr]) + 16384) >>> 15;
      phase_acc = phase_acc + cur_step;
    end else if (cur_mode == MODE_QTR) begin
      case (quarter_pos)
        2'd0:    begin ri = s;  rq = 0;  end
        2'd1:    begin ri = 0;  rq = -s; end
        2'd2:    begin ri = -s; rq = 0;  end
        default: begin ri = 0;  rq = s;  end
      endcase
      quarter_pos = quarter_pos + 2'd1;
    end else begin
      ri = s;
      rq = 0;
    end
    if (cur_decim) begin
      if (!half_held) begin
        held_i = ri;
        held_q = rq;
        half_held = 1'b1;
        return;
      end
      ri += held_i;
      rq += held_q;
      half_held = 1'b0;
    end else begin
      half_held = 1'b0;
    end
    expected_iq.push_back('{i_val: ri[OUT_W-1:0], q_val: rq[OUT_W-1:0]});
  endfunction

  // Input side: predict on each transfer, then draw the gap before the next offer.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      downconvert_sample(in_sample);
      samples_sent++;
      offer_open = 1'b0;
      send_wait = $urandom_range(0, send_gap_max);
    end
  end

  // Hold the payload while stalled; advance to the next pending sample after a transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!offer_open) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        in_sample <= pending_samples.pop_front();
        in_valid <= 1'b1;
        offer_open = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      recv_wait = $urandom_range(0, recv_gap_max);
      if (expected_iq.size() == 0) begin
        $error("result with none expected: i_out %0d q_out %0d", out_i_out, out_q_out);
        error_count++;
      end else begin
        want = expected_iq.pop_front();
        if (out_i_out !== want.i_val) begin
          $error("i_out mismatch: expected %0d, got %0d", want.i_val, out_i_out);
          error_count++;
        end
        if (out_q_out !== want.q_val) begin
          $error("q_out mismatch: expected %0d, got %0d", want.q_val, out_q_out);
          error_count++;
        end
      end
    end
  end

  // Stall the result side: a long hold when requested, else the drawn per-result wait.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
        long_holds++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Wait until every sample is taken and every result has arrived, then let a
  // half pair still in the pipeline settle.
  task automatic settle();
    while (pending_samples.size() != 0 || offer_open || expected_iq.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      REG_MIX_MODE:   cur_mode = val[MODE_W-1:0];
      REG_PHASE_STEP: cur_step = val[STEP_W-1:0];
      REG_DECIMATE:   cur_decim = val[0];
      default:        ;
    endcase
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode, input logic [STEP_W-1:0] step,
                           input logic decim, input int sgap, input int rgap);
    settle();
    write_reg(REG_MIX_MODE, CFG_DATA_W'(mode));
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_DECIMATE, CFG_DATA_W'(decim));
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_gap_max = sgap;
    recv_gap_max = rgap;
  endtask

  task automatic offer(input int v);
    pending_samples.push_back(v[SAMPLE_BITS-1:0]);
  endtask

  // Mostly uniform samples, with the extremes mixed in.
  task automatic random_block(input int count, input bit hold, input bit pause);
    int pick;
    if (hold) begin
      hold_req = 1'b1;
    end
    for (int n = 0; n < count; n++) begin
      if (pause && n == count / 2) begin
        settle();
      end
      pick = $urandom_range(0, 15);
      case (pick)
        0:       offer(-32768);
        1:       offer(32767);
        2:       offer(0);
        3:       offer(-1);
        default: offer(int'($urandom));
      endcase
    end
  endtask

  initial begin
    build_wave_tables();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Pass-through at the sample extremes
    configure(MODE_PASS, '0, 1'b0, 0, 0);
    offer(-32768); offer(32767); offer(0); offer(-1); offer(1);
    // NCO parked at phase zero: rounding ties go upward
    configure(MODE_NCO, '0, 1'b0, 1, 1);
    offer(16384); offer(-16384); offer(32767);
    // NCO stepping a quarter turn per sample through all four quadrants
    configure(MODE_NCO, 32'h4000_0000, 1'b0, 2, 2);
    offer(-32768); offer(32767); offer(-32768); offer(32767); offer(12345);
    // Quarter-rate with pair sums; odd count leaves a half pair held
    configure(MODE_QTR, '0, 1'b1, 0, 3);
    offer(-32768); offer(-32768); offer(32767); offer(32767);
    offer(-32768); offer(32767); offer(7);
    // Spare mode passes through; turning decimation off drops the held half
    configure(MODE_SPARE, 32'hFFFF_FFFF, 1'b0, 0, 0);
    offer(-32768); offer(100);

    // Random part: back-to-back stretch first, then heavy idling on both sides
    configure(MODE_PASS, '0, 1'b0, 0, 0);
    random_block(60, 1'b0, 1'b0);
    configure(MODE_NCO, $urandom, 1'b0, 8, 8);
    random_block(150, 1'b0, 1'b0);
    configure(MODE_NCO, 32'hFFFF_FFFF, 1'b1, 4, 4);
    random_block(101, 1'b0, 1'b0);
    // Long receiver hold while samples keep coming: the core must back up
    configure(MODE_QTR, '0, 1'b1, 2, 3);
    random_block(120, 1'b1, 1'b0);
    // Sender drains the core halfway through
    configure(MODE_NCO, 32'($urandom_range(1, 1 << 20)), 1'b1, 8, 0);
    random_block(121, 1'b0, 1'b1);
    configure(MODE_SPARE, $urandom, 1'b0, 3, 8);
    random_block(60, 1'b0, 1'b0);
    configure(MODE_QTR, '0, 1'b0, 0, 8);
    random_block(100, 1'b0, 1'b0);
    configure(MODE_PASS, '0, 1'b1, 8, 2);
    random_block(81, 1'b0, 1'b0);
    configure(MODE_NCO, $urandom, 1'b0, 1, 1);
    random_block(137, 1'b0, 1'b0);

    settle();
    $display("Covered %0d samples and %0d results across pass, NCO, quarter-rate and spare modes,",
             samples_sent, results_seen);
    $display("with and without pair sums, step extremes, and %0d long result-side holds.",
             long_holds);
    if (error_count == 0 && expected_iq.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
